### rtl/rpn_pkg.sv
`default_nettype none
package rpn_pkg;
   localparam int StackDepth = 16;
   localparam int FracBits = 16;
   localparam int DataWidth = 48;
   localparam int PtrWidth = $clog2(StackDepth);
   localparam int CountWidth = $clog2(StackDepth + 1);
   localparam int DivBits = DataWidth + FracBits;
   localparam int DivCntWidth = $clog2(DivBits + 1);

   typedef enum logic [2:0] {
      FUNC_PUSH = 3'd0,
      FUNC_ADD  = 3'd1,
      FUNC_SUB  = 3'd2,
      FUNC_MUL  = 3'd3,
      FUNC_DIV  = 3'd4
   } func_type;

   typedef enum logic [1:0] {
      ERR_OK        = 2'd0,
      ERR_UNDERFLOW = 2'd1,
      ERR_OVERFLOW  = 2'd2,
      ERR_DIV_ZERO  = 2'd3
   } err_type;

   typedef struct packed {
      logic load_req;
      logic rd_second;
      logic rd_first;
      logic latch_second;
      logic latch_first;
      logic start_op;
      logic step_op;
      logic write_result;
      logic write_push;
      logic rd_top;
      logic report;
   } cmd_type;

   typedef struct packed {
      logic [2:0] func;
      logic last;
      logic [CountWidth-1:0] count;
      logic second_zero;
      logic op_done;
   } status_type;
endpackage
`default_nettype wire

### rtl/rpn_ram.sv
`default_nettype none
module rpn_ram #(
   parameter int Width = 48,
   parameter int Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]              rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

### rtl/rpn_datapath.sv
`default_nettype none
module rpn_datapath (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire rpn_pkg::cmd_type             cmd,
   output rpn_pkg::status_type               status,
   input  wire logic [2:0]                   req_func,
   input  wire logic [rpn_pkg::DataWidth-1:0] req_value,
   input  wire logic                         req_last,
   input  wire logic [1:0]                   err_code,
   output logic [rpn_pkg::DataWidth-1:0]     rsp_top_value,
   output logic [4:0]                        rsp_depth,
   output logic [1:0]                        rsp_error,
   output logic                              rsp_last_clear
);
   import rpn_pkg::*;

   localparam int W = DataWidth;
   localparam int PW = 2 * W;
   localparam logic [W-1:0] MaxPos = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] MinNeg = {1'b1, {(W-1){1'b0}}};
   localparam logic [W:0] MaxMag = {2'b00, {(W-1){1'b1}}};
   localparam logic [W:0] NegMag = {2'b01, {(W-1){1'b0}}};

   logic [2:0] func_ff;
   logic [W-1:0] value_ff;
   logic last_ff;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [W-1:0] first_ff, second_ff;
   logic [W-1:0] result_ff, result_in;
   logic [PW-1:0] prod_ff, prod_in;
   logic [W-1:0] mcand_ff, mcand_in;
   logic [W-1:0] mplier_ff, mplier_in;
   logic [DivBits-1:0] num_ff, num_in;
   logic [W:0] rem_ff, rem_in;
   logic [DivCntWidth-1:0] iter_ff, iter_in;
   logic neg_ff, neg_in;

   logic wr_en;
   logic [PtrWidth-1:0] wr_addr, rd_addr;
   logic [W-1:0] wr_data, rd_data;

   rpn_ram #(.Width(W), .Depth(StackDepth)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   logic [CountWidth-1:0] cm1, cm2;
   assign cm1 = count_ff - CountWidth'(1);
   assign cm2 = count_ff - CountWidth'(2);

   always_comb begin
      rd_addr = cm1[PtrWidth-1:0];
      if (cmd.rd_first) begin
         rd_addr = cm2[PtrWidth-1:0];
      end
      wr_en = cmd.write_result | cmd.write_push;
      wr_addr = cmd.write_push ? count_ff[PtrWidth-1:0] : cm2[PtrWidth-1:0];
      wr_data = cmd.write_push ? value_ff : result_ff;
   end

   logic [W-1:0] mag_a, mag_b;
   logic [W:0] sum;
   logic [W:0] sa, sb;
   logic [W:0] trial;
   logic [PW-1:0] shifted;
   logic [PW-1:0] qmag;
   logic [W:0] mag_sat;

   always_comb begin
      mag_a = first_ff[W-1] ? (~first_ff + W'(1)) : first_ff;
      mag_b = second_ff[W-1] ? (~second_ff + W'(1)) : second_ff;
      sa = {first_ff[W-1], first_ff};
      sb = {second_ff[W-1], second_ff};
      sum = (func_ff == FUNC_SUB) ? (sa - sb) : (sa + sb);
      prod_in = prod_ff;
      mcand_in = mcand_ff;
      mplier_in = mplier_ff;
      num_in = num_ff;
      rem_in = rem_ff;
      iter_in = iter_ff;
      neg_in = neg_ff;
      result_in = result_ff;
      trial = {rem_ff[W-1:0], num_ff[DivBits-1]} - {1'b0, mcand_ff};
      shifted = '0;
      qmag = '0;
      mag_sat = '0;
      if (cmd.start_op) begin
         neg_in = first_ff[W-1] ^ second_ff[W-1];
         prod_in = '0;
         mcand_in = mag_a;
         mplier_in = mag_b;
         iter_in = '0;
         if (func_ff == FUNC_DIV) begin
            mcand_in = mag_b;
            num_in = {mag_a, FracBits'(0)};
            rem_in = '0;
         end
         if (func_ff == FUNC_ADD || func_ff == FUNC_SUB) begin
            if (sum[W] != sum[W-1]) begin
               result_in = sum[W] ? MinNeg : MaxPos;
            end else begin
               result_in = sum[W-1:0];
            end
         end
      end else if (cmd.step_op) begin
         iter_in = iter_ff + DivCntWidth'(1);
         if (func_ff == FUNC_MUL) begin
            if (mplier_ff[W-1]) begin
               prod_in = {prod_ff[PW-2:0], 1'b0} + {{W{1'b0}}, mcand_ff};
            end else begin
               prod_in = {prod_ff[PW-2:0], 1'b0};
            end
            mplier_in = {mplier_ff[W-2:0], 1'b0};
         end else begin
            num_in = {num_ff[DivBits-2:0], 1'b0};
            if (!trial[W]) begin
               rem_in = trial;
               prod_in = {prod_ff[PW-2:0], 1'b1};
            end else begin
               rem_in = {rem_ff[W-1:0], num_ff[DivBits-1]};
               prod_in = {prod_ff[PW-2:0], 1'b0};
            end
         end
      end else if (cmd.write_result && func_ff == FUNC_MUL) begin
         result_in = result_ff;
      end
      if (func_ff == FUNC_MUL) begin
         shifted = prod_ff >> FracBits;
      end else begin
         shifted = prod_ff;
      end
      qmag = shifted;
      if (qmag[PW-1:W+1] != '0) begin
         mag_sat = neg_ff ? NegMag : MaxMag;
      end else if (neg_ff && qmag[W:0] > NegMag) begin
         mag_sat = NegMag;
      end else if (!neg_ff && qmag[W:0] > MaxMag) begin
         mag_sat = MaxMag;
      end else begin
         mag_sat = qmag[W:0];
      end
      if (cmd.latch_first && (func_ff == FUNC_MUL || func_ff == FUNC_DIV)) begin
         result_in = result_ff;
      end
      if (status.op_done && !cmd.step_op && !cmd.start_op &&
          (func_ff == FUNC_MUL || func_ff == FUNC_DIV) && !cmd.write_result) begin
         result_in = neg_ff ? W'(~mag_sat + (W+1)'(1)) : mag_sat[W-1:0];
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.write_push) begin
         count_in = count_ff + CountWidth'(1);
      end else if (cmd.write_result) begin
         count_in = cm1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.report && last_ff) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      if (cmd.load_req) begin
         func_ff <= req_func;
         value_ff <= req_value;
         last_ff <= req_last;
      end
      if (cmd.latch_second) begin
         second_ff <= rd_data;
      end
      if (cmd.latch_first) begin
         first_ff <= rd_data;
      end
      if (cmd.report) begin
         rsp_top_value <= (count_ff == '0) ? '0 : rd_data;
         rsp_depth <= 5'(count_ff);
         rsp_error <= err_code;
         rsp_last_clear <= last_ff;
      end
      result_ff <= result_in;
      prod_ff <= prod_in;
      mcand_ff <= mcand_in;
      mplier_ff <= mplier_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      iter_ff <= iter_in;
      neg_ff <= neg_in;
   end

   always_comb begin
      status.func = func_ff;
      status.last = last_ff;
      status.count = count_ff;
      status.second_zero = (second_ff == '0);
      status.op_done = (func_ff == FUNC_MUL) ? (iter_ff == DivCntWidth'(W))
                                             : (iter_ff == DivCntWidth'(DivBits));
   end
endmodule
`default_nettype wire

### rtl/rpn_ctrl.sv
`default_nettype none
module rpn_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   input  wire rpn_pkg::status_type status,
   output rpn_pkg::cmd_type         cmd,
   output logic [1:0]               err_code
);
   import rpn_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_RD2, S_RD1, S_LATCH1, S_START, S_STEP, S_FINISH,
      S_WRITE, S_RDTOP, S_REPORT
   } state_type;

   state_type state_ff, state_in;
   logic [1:0] err_ff, err_in;
   logic rsp_valid_ff, rsp_valid_in;

   assign req_tready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign err_code = err_ff;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      err_in = err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               cmd.load_req = 1'b1;
               err_in = ERR_OK;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (status.func)
               FUNC_PUSH: begin
                  if (status.count >= CountWidth'(StackDepth)) begin
                     err_in = ERR_OVERFLOW;
                  end else begin
                     cmd.write_push = 1'b1;
                  end
                  state_in = S_RDTOP;
               end
               FUNC_ADD, FUNC_SUB, FUNC_MUL, FUNC_DIV: begin
                  if (status.count < CountWidth'(2)) begin
                     err_in = ERR_UNDERFLOW;
                     state_in = S_RDTOP;
                  end else begin
                     cmd.rd_second = 1'b1;
                     state_in = S_RD2;
                  end
               end
               default: state_in = S_RDTOP;
            endcase
         end
         S_RD2: begin
            cmd.rd_first = 1'b1;
            cmd.latch_second = 1'b1;
            state_in = S_LATCH1;
         end
         S_LATCH1: begin
            cmd.latch_first = 1'b1;
            state_in = S_START;
         end
         S_START: begin
            if (status.func == FUNC_DIV && status.second_zero) begin
               err_in = ERR_DIV_ZERO;
               state_in = S_RDTOP;
            end else begin
               cmd.start_op = 1'b1;
               if (status.func == FUNC_ADD || status.func == FUNC_SUB) begin
                  state_in = S_WRITE;
               end else begin
                  state_in = S_STEP;
               end
            end
         end
         S_STEP: begin
            if (status.op_done) begin
               state_in = S_WRITE;
            end else begin
               cmd.step_op = 1'b1;
            end
         end
         S_WRITE: begin
            cmd.write_result = 1'b1;
            state_in = S_RDTOP;
         end
         S_RDTOP: begin
            cmd.rd_top = 1'b1;
            state_in = S_REPORT;
         end
         S_REPORT: begin
            cmd.report = 1'b1;
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         err_ff <= ERR_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         err_ff <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule
`default_nettype wire

### rtl/rpn_stack_evaluator_top.sv
// Channel   Direction  tdata (low bit first)              tuser   tlast
// req       in         func[2:0], value[50:3], pad to 56  none    last
// rsp       out        top_value[47:0], depth[52:48],     none    last
//                      error[54:53], pad to 56
// A push is decoded, written and reported; an add or subtract also reads both operands and writes back.
// Multiply and divide are computed by the shared
// one-bit-per-cycle shift-add/subtract unit iterating over the operand bits.
// Reset is synchronous and clears the stack count; stack contents are not cleared.
// A new request is taken only after the previous result has been taken.
`default_nettype none
module rpn_stack_evaluator_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [55:0] req_tdata,   // func, value
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [55:0]      rsp_tdata,   // top_value, depth, error
   output logic             rsp_tlast
);
   import rpn_pkg::*;

   cmd_type cmd;
   status_type status;
   logic [1:0] err_code;
   logic [DataWidth-1:0] top_value;
   logic [4:0] depth;
   logic [1:0] error;

   rpn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .status    (status),
      .cmd       (cmd),
      .err_code  (err_code)
   );

   rpn_datapath u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_func      (req_tdata[2:0]),
      .req_value     (req_tdata[50:3]),
      .req_last      (req_tlast),
      .err_code      (err_code),
      .rsp_top_value (top_value),
      .rsp_depth     (depth),
      .rsp_error     (error),
      .rsp_last_clear(rsp_tlast)
   );

   assign rsp_tdata = {1'b0, error, depth, top_value};
endmodule
`default_nettype wire

### rtl/rpn_checker.sv
`default_nettype none
module rpn_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [55:0] rsp_tdata
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("Result changed while stalled.");
   a_no_accept_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("Request taken while a result is pending.");
   a_depth_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[52:48] <= 5'd16)
      else $error("Depth out of range.");
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[52:48] == 5'd0 |-> rsp_tdata[47:0] == 48'd0)
      else $error("Empty stack reports nonzero top.");
endmodule

bind rpn_stack_evaluator_top rpn_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);
`default_nettype wire

### bench/rpn_stack_evaluator_top_tb.sv
`timescale 1ns / 1ps
module rpn_stack_evaluator_top_tb;
   import rpn_pkg::*;

   typedef struct {
      logic [47:0] top;
      logic [4:0]  depth;
      err_type     err;
      logic        last;
   } report_type;

   class stack_scoreboard;
      logic [47:0] operands [StackDepth];
      int          count;
      report_type  pending [$];
      int          failures;
      int          checked;

      function logic [47:0] clamp(logic neg, logic [95:0] mag);
         logic [95:0] limit;
         limit = neg ? 96'h8000_0000_0000 : 96'h7FFF_FFFF_FFFF;
         if (mag > limit) mag = limit;
         return neg ? 48'(-mag[47:0]) : mag[47:0];
      endfunction

      function void note_request(logic [2:0] func, logic [47:0] value, logic last);
         report_type r;
         logic [47:0] a, b, res, x, y;
         logic signed [48:0] sum;
         logic [63:0] quot;
         logic neg;
         r.err = ERR_OK;
         res = '0;
         if (func == FUNC_PUSH) begin
            if (count >= StackDepth) r.err = ERR_OVERFLOW;
            else begin
               operands[count] = value;
               count++;
            end
         end else if (func <= FUNC_DIV) begin
            if (count < 2) r.err = ERR_UNDERFLOW;
            else begin
               b = operands[count-1];
               a = operands[count-2];
               neg = a[47] ^ b[47];
               x = a[47] ? -a : a;
               y = b[47] ? -b : b;
               case (func)
                  FUNC_ADD, FUNC_SUB: begin
                     sum = (func == FUNC_ADD) ? $signed({a[47], a}) + $signed({b[47], b})
                                              : $signed({a[47], a}) - $signed({b[47], b});
                     if (sum > 49'sh0_7FFF_FFFF_FFFF) res = 48'h7FFF_FFFF_FFFF;
                     else if (sum < -49'sh0_8000_0000_0000) res = 48'h8000_0000_0000;
                     else res = sum[47:0];
                  end
                  FUNC_MUL: res = clamp(neg, (96'(x) * 96'(y)) >> FracBits);
                  default: begin
                     if (b == 0) r.err = ERR_DIV_ZERO;
                     else begin
                        quot = {x[47:0], 16'b0} / 64'(y);
                        res = clamp(neg, 96'(quot));
                     end
                  end
               endcase
               if (r.err == ERR_OK) begin
                  operands[count-2] = res;
                  count--;
               end
            end
         end
         r.top = (count > 0) ? operands[count-1] : '0;
         r.depth = 5'(count);
         r.last = last;
         pending.push_back(r);
         if (last) count = 0;
      endfunction

      function void check_result(logic [55:0] data, logic last);
         report_type e;
         checked++;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result %h", $time, data);
            failures++;
            return;
         end
         e = pending.pop_front();
         if (data[47:0] !== e.top) begin
            $display("%0t: top expected %h actual %h", $time, e.top, data[47:0]);
            failures++;
         end
         if (data[52:48] !== e.depth) begin
            $display("%0t: depth expected %0d actual %0d", $time, e.depth, data[52:48]);
            failures++;
         end
         if (data[54:53] !== e.err) begin
            $display("%0t: error expected %0d actual %0d", $time, e.err, data[54:53]);
            failures++;
         end
         if (last !== e.last) begin
            $display("%0t: last expected %b actual %b", $time, e.last, last);
            failures++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0, req_tready, req_tlast = 0;
   logic [55:0] req_tdata = '0;
   logic rsp_tvalid, rsp_tready = 0, rsp_tlast;
   logic [55:0] rsp_tdata;

   stack_scoreboard sb = new();
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int tokens_sent = 0;
   int model_depth = 0;

   rpn_stack_evaluator_top i_dut (.*);

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tlast);
      rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   task automatic send_token(logic [2:0] func, logic [47:0] value, logic last);
      int gap;
      gap = 0;
      while ($urandom_range(0, 99) < send_idle_pct && gap < 40) gap++;
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {5'b0, value, func};
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      sb.note_request(func, value, last);
      tokens_sent++;
      if (func == FUNC_PUSH && model_depth < StackDepth) model_depth++;
      else if (func != FUNC_PUSH && func <= FUNC_DIV && model_depth >= 2) model_depth--;
      if (last) model_depth = 0;
   endtask

   function automatic logic [47:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 48'h7FFF_FFFF_FFFF;
         1: return 48'h8000_0000_0000;
         2: return '0;
         3, 4: return 48'({$urandom, $urandom});
         default: return 48'(signed'($urandom_range(0, 32'h3F_FFFF)) - 32'sh20_0000);
      endcase
   endfunction

   task automatic random_expression();
      int len;
      logic [2:0] op;
      len = $urandom_range(2, 24);
      for (int i = 0; i < len; i++) begin
         if (model_depth < 2 || (model_depth < StackDepth && $urandom_range(0, 1)))
            send_token(FUNC_PUSH, pick_value(), 0);
         else begin
            op = 3'($urandom_range(FUNC_ADD, FUNC_DIV));
            send_token(op, pick_value(), 0);
         end
      end
      while (model_depth > 1)
         send_token(3'($urandom_range(FUNC_ADD, FUNC_DIV)), pick_value(), 0);
      send_token(3'($urandom_range(FUNC_ADD, FUNC_DIV)), pick_value(), 1);
   endtask

   task automatic random_phase(int quota);
      int start;
      start = tokens_sent;
      while (tokens_sent - start < quota) begin
         if ($urandom_range(0, 99) < 15)
            send_token(3'($urandom_range(0, 7)), 48'({$urandom, $urandom}),
                       1'($urandom_range(0, 1)));
         else random_expression();
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 0;
      send_token(FUNC_ADD, 48'h1, 0);
      send_token(FUNC_PUSH, 48'h7FFF_FFFF_FFFF, 0);
      send_token(FUNC_PUSH, 48'h7FFF_FFFF_FFFF, 0);
      send_token(FUNC_ADD, '0, 0);
      send_token(FUNC_PUSH, 48'h8000_0000_0000, 0);
      send_token(FUNC_SUB, '0, 0);
      send_token(FUNC_PUSH, 48'h8000_0000_0000, 0);
      send_token(FUNC_MUL, '0, 0);
      send_token(FUNC_PUSH, '0, 0);
      send_token(FUNC_DIV, '0, 0);
      send_token(3'd5, '1, 0);
      send_token(3'd6, '0, 0);
      send_token(3'd7, '1, 1);
      for (int i = 0; i < StackDepth + 1; i++)
         send_token(FUNC_PUSH, 48'(i) << FracBits | 48'h8000, 0);
      send_token(FUNC_DIV, '0, 0);
      send_token(FUNC_MUL, '0, 1);
      for (int ph = 0; ph < 4; ph++) begin
         req_tvalid <= 0;
         wait (sb.pending.size() == 0);
         send_idle_pct = (ph == 1) ? 85 : (ph == 3) ? 17 : 0;
         recv_stall_pct = (ph == 2) ? 85 : (ph == 3) ? 17 : 0;
         random_phase(375);
      end
      req_tvalid <= 0;
      recv_stall_pct = 0;
      wait (sb.pending.size() == 0);
      repeat (100) @(posedge clock);
      $display("Sent %0d tokens and checked %0d results across four handshake phases.",
               tokens_sent, sb.checked);
      if (sb.failures == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #50ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
